>>> rtl/sdc_pkg.sv
// shared types and constants for the stick deadzone conditioner
package sdc_pkg;

    localparam int AXIS_W    = 16;
    localparam int MAG_W     = 15;
    localparam int DIV_STEPS = 15;
    localparam int PROD_W    = 2 * MAG_W;

    localparam logic [MAG_W-1:0] DZ_LIMIT = 15'd32766;
    localparam logic [MAG_W-1:0] DZ_MAX   = 15'd32767;

    // configuration register indexes
    localparam logic [2:0] REG_INVERT_MASK    = 3'd0;
    localparam logic [2:0] REG_DEADZONE_LEFT  = 3'd1;
    localparam logic [2:0] REG_DEADZONE_RIGHT = 3'd2;
    localparam logic [2:0] REG_LINKED_LEFT    = 3'd3;
    localparam logic [2:0] REG_LINKED_RIGHT   = 3'd4;
    localparam logic [2:0] REG_RESCALE_LEFT   = 3'd5;
    localparam logic [2:0] REG_RESCALE_RIGHT  = 3'd6;

    typedef struct packed {
        logic signed [AXIS_W-1:0] left_x;
        logic signed [AXIS_W-1:0] left_y;
        logic signed [AXIS_W-1:0] right_x;
        logic signed [AXIS_W-1:0] right_y;
    } sdc_in_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] out_left_x;
        logic signed [AXIS_W-1:0] out_left_y;
        logic signed [AXIS_W-1:0] out_right_x;
        logic signed [AXIS_W-1:0] out_right_y;
    } sdc_out_t;

    // per-lane request entering the divider pipeline
    typedef struct packed {
        logic [AXIS_W-1:0] value;
        logic              zero;
        logic              do_div;
        logic [PROD_W-1:0] dividend;
    } lane_req_t;

endpackage

>>> rtl/sdc_div_lane.sv
// one axis lane: pipelined restoring divider with pass-through and zeroing
module sdc_div_lane (
    input  logic                         aclk,
    input  logic [sdc_pkg::DIV_STEPS:0]  en,
    input  sdc_pkg::lane_req_t           req,
    input  logic [sdc_pkg::MAG_W-1:0]    divisor,
    output logic [sdc_pkg::AXIS_W-1:0]   result
);
    import sdc_pkg::*;

    logic [AXIS_W-1:0] val_reg  [0:DIV_STEPS];
    logic              zero_reg [0:DIV_STEPS];
    logic              div_reg  [0:DIV_STEPS];
    logic [MAG_W:0]    rem_reg  [0:DIV_STEPS];
    logic [MAG_W-1:0]  low_reg  [0:DIV_STEPS];
    logic [MAG_W-1:0]  quo_reg  [0:DIV_STEPS];

    // stage 0 loads the request, top half of dividend as partial remainder
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            val_reg[0]  <= req.value;
            zero_reg[0] <= req.zero;
            div_reg[0]  <= req.do_div;
            rem_reg[0]  <= {1'b0, req.dividend[PROD_W-1:MAG_W]};
            low_reg[0]  <= req.dividend[MAG_W-1:0];
            quo_reg[0]  <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [MAG_W:0] trial;
        logic           fits;
        assign trial = {rem_reg[k][MAG_W-1:0], low_reg[k][MAG_W-1]};
        assign fits  = trial >= {1'b0, divisor};
        always_ff @(posedge aclk) begin
            if (en[k+1]) begin
                val_reg[k+1]  <= val_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                div_reg[k+1]  <= div_reg[k];
                rem_reg[k+1]  <= fits ? (trial - {1'b0, divisor}) : trial;
                low_reg[k+1]  <= {low_reg[k][MAG_W-2:0], 1'b0};
                quo_reg[k+1]  <= {quo_reg[k][MAG_W-2:0], fits};
            end
        end
    end

    // final select, quotient is inverted again for negative axes
    always_comb begin
        if (zero_reg[DIV_STEPS]) begin
            result = '0;
        end else if (div_reg[DIV_STEPS]) begin
            result = val_reg[DIV_STEPS][AXIS_W-1] ? ~{1'b0, quo_reg[DIV_STEPS]}
                                                  : {1'b0, quo_reg[DIV_STEPS]};
        end else begin
            result = val_reg[DIV_STEPS];
        end
    end

endmodule

>>> rtl/stick_deadzone_conditioner_top.sv
// top level: configuration, per-stick deadzone decisions, four lanes, output stage
//
// Two-stick deadzone conditioner. Each request carries four signed 16-bit axes
// and gives one result request. Axes are inverted per the invert mask, tested
// against each stick's deadzone (jointly in linked mode) and optionally
// rescaled to full range by an exact integer divide. One request is accepted
// per cycle while the output is not stalled. Each axis runs through the entry
// stage, a 15-stage divider pipeline and the output stage. Stages advance
// independently, so bubbles are squeezed out under stall. Configuration is
// written through cfg_wr_en/cfg_index/cfg_wdata; the user must write it only
// while idle, as the block itself does not enforce this.
module stick_deadzone_conditioner_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [sdc_pkg::MAG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sdc_pkg::sdc_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sdc_pkg::sdc_out_t             m_data
);
    import sdc_pkg::*;

    localparam int LAST = DIV_STEPS + 1;

    logic [3:0]       invert_mask_reg;
    logic [MAG_W-1:0] dz_left_reg, dz_right_reg;
    logic             linked_left_reg, linked_right_reg;
    logic             rescale_left_reg, rescale_right_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_mask_reg   <= '0;
            dz_left_reg       <= '0;
            dz_right_reg      <= '0;
            linked_left_reg   <= 1'b0;
            linked_right_reg  <= 1'b0;
            rescale_left_reg  <= 1'b0;
            rescale_right_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_INVERT_MASK:    invert_mask_reg   <= cfg_wdata[3:0];
                REG_DEADZONE_LEFT:  dz_left_reg       <= cfg_wdata;
                REG_DEADZONE_RIGHT: dz_right_reg      <= cfg_wdata;
                REG_LINKED_LEFT:    linked_left_reg   <= cfg_wdata[0];
                REG_LINKED_RIGHT:   linked_right_reg  <= cfg_wdata[0];
                REG_RESCALE_LEFT:   rescale_left_reg  <= cfg_wdata[0];
                REG_RESCALE_RIGHT:  rescale_right_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // clamp deadzones so the divisor stays nonzero
    logic [MAG_W-1:0] d_left, d_right;
    assign d_left  = (dz_left_reg == DZ_MAX) ? DZ_LIMIT : dz_left_reg;
    assign d_right = (dz_right_reg == DZ_MAX) ? DZ_LIMIT : dz_right_reg;

    logic [MAG_W-1:0] div_left, div_right;
    assign div_left  = DZ_MAX - d_left;
    assign div_right = DZ_MAX - d_right;

    // axis inversion
    logic [AXIS_W-1:0] ax [0:3];
    assign ax[0] = invert_mask_reg[0] ? ~s_data.left_x  : s_data.left_x;
    assign ax[1] = invert_mask_reg[1] ? s_data.left_y   : ~s_data.left_y;
    assign ax[2] = invert_mask_reg[2] ? ~s_data.right_x : s_data.right_x;
    assign ax[3] = invert_mask_reg[3] ? s_data.right_y  : ~s_data.right_y;

    // deadzone decisions and dividend per axis
    lane_req_t req [0:3];
    always_comb begin
        logic [MAG_W-1:0] mag [0:3];
        logic [MAG_W-1:0] dd, diff;
        logic             below [0:3];
        logic             lnk, rsc, on, zero;
        for (int i = 0; i < 4; i++) begin
            mag[i] = ax[i][AXIS_W-1] ? ~ax[i][MAG_W-1:0] : ax[i][MAG_W-1:0];
        end
        for (int i = 0; i < 4; i++) begin
            dd  = (i < 2) ? d_left : d_right;
            below[i] = mag[i] < dd;
        end
        for (int i = 0; i < 4; i++) begin
            dd   = (i < 2) ? d_left : d_right;
            lnk  = (i < 2) ? linked_left_reg : linked_right_reg;
            rsc  = (i < 2) ? rescale_left_reg : rescale_right_reg;
            on   = dd != '0;
            zero = lnk ? (below[i & 2] && below[(i & 2) + 1]) : below[i];
            diff = mag[i] - dd;
            req[i].value    = ax[i];
            req[i].do_div   = on && rsc;
            req[i].zero     = on && (zero || (rsc && (mag[i] <= dd)));
            req[i].dividend = {diff, {MAG_W{1'b0}}} - {{MAG_W{1'b0}}, diff};
        end
    end

    // per-stage valids with independent advance
    logic [LAST:0] vld_reg, vld_next, rdy;
    always_comb begin
        rdy[LAST] = !vld_reg[LAST] || m_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? s_valid : vld_reg[0];
        for (int k = 1; k <= LAST; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = vld_reg[LAST];

    // four axis lanes
    logic [AXIS_W-1:0] lane_out [0:3];
    for (genvar i = 0; i < 4; i++) begin : g_lane
        sdc_div_lane u_lane (
            .aclk    (aclk),
            .en      (rdy[DIV_STEPS:0]),
            .req     (req[i]),
            .divisor ((i < 2) ? div_left : div_right),
            .result  (lane_out[i])
        );
    end

    // merge lanes into the output register
    sdc_out_t out_reg;
    always_ff @(posedge aclk) begin
        if (rdy[LAST]) begin
            out_reg.out_left_x  <= lane_out[0];
            out_reg.out_left_y  <= lane_out[1];
            out_reg.out_right_x <= lane_out[2];
            out_reg.out_right_y <= lane_out[3];
        end
    end
    assign m_data = out_reg;

endmodule

>>> sim/stick_deadzone_conditioner_top_tb.sv
// testbench for the stick deadzone conditioner: random and directed requests checked against a predictor
module stick_deadzone_conditioner_top_tb;
    import sdc_pkg::*;

    // index outside the register list, writes to it are ignored
    localparam logic [2:0] REG_NONE = 3'd7;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [MAG_W-1:0]   cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    sdc_in_t            s_data;
    logic               m_valid;
    logic               m_ready;
    sdc_out_t           m_data;
    logic               s_ready_q;

    // predictor copy of the configuration
    logic [3:0]         inv_mask_q;
    logic [MAG_W-1:0]   dz_left_q;
    logic [MAG_W-1:0]   dz_right_q;
    logic               link_left_q;
    logic               link_right_q;
    logic               resc_left_q;
    logic               resc_right_q;

    sdc_in_t            pending_axes[$];
    sdc_out_t           expected_axes[$];
    int                 error_count;

    stick_deadzone_conditioner_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // clock
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic logic [15:0] axis_mag(logic [15:0] v);
        return v[15] ? ~v : v;
    endfunction

    function automatic logic [15:0] rescale_axis(logic [15:0] v, logic [15:0] d);
        logic [31:0] m;
        logic [31:0] q;
        m = {16'd0, axis_mag(v)};
        if (m <= d) begin
            return 16'd0;
        end
        q = (32'd32767 * (m - d)) / (32'd32767 - d);
        return v[15] ? ~q[15:0] : q[15:0];
    endfunction

    // deadzone and rescale for one stick
    function automatic void condition_stick(inout logic [15:0] x, inout logic [15:0] y,
                                            input logic [MAG_W-1:0] dz,
                                            input logic linked, input logic resc);
        logic [15:0] d;
        logic        xs;
        logic        ys;
        d = {1'b0, dz};
        if (d > 16'd32766) begin
            d = 16'd32766;
        end
        if (d == 16'd0) begin
            return;
        end
        xs = axis_mag(x) < d;
        ys = axis_mag(y) < d;
        if (linked) begin
            if (xs && ys) begin
                x = 16'd0;
                y = 16'd0;
            end else if (resc) begin
                x = rescale_axis(x, d);
                y = rescale_axis(y, d);
            end
        end else begin
            if (xs) begin
                x = 16'd0;
            end else if (resc) begin
                x = rescale_axis(x, d);
            end
            if (ys) begin
                y = 16'd0;
            end else if (resc) begin
                y = rescale_axis(y, d);
            end
        end
    endfunction

    function automatic sdc_out_t condition_axes(sdc_in_t a);
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
        sdc_out_t    r;
        lx = inv_mask_q[0] ? ~a.left_x : a.left_x;
        ly = inv_mask_q[1] ? a.left_y : ~a.left_y;
        rx = inv_mask_q[2] ? ~a.right_x : a.right_x;
        ry = inv_mask_q[3] ? a.right_y : ~a.right_y;
        condition_stick(lx, ly, dz_left_q, link_left_q, resc_left_q);
        condition_stick(rx, ry, dz_right_q, link_right_q, resc_right_q);
        r.out_left_x  = lx;
        r.out_left_y  = ly;
        r.out_right_x = rx;
        r.out_right_y = ry;
        return r;
    endfunction

    // request driver: bursts with random gaps
    int burst_left;
    int gap_left;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!(s_valid && !s_ready_q)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (pending_axes.size() > 0) begin
                s_data  <= pending_axes.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // acceptance seen at the rising edge
    always @(posedge aclk) begin
        s_ready_q <= 1'b0;
        if (aresetn && s_valid && s_ready) begin
            s_ready_q <= 1'b1;
            expected_axes.push_back(condition_axes(s_data));
        end
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(negedge aclk) begin
        stall_phase <= stall_phase + 1;
        if ((stall_phase / 64) % 3 == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 11 != 5);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        sdc_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_axes.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_data);
                error_count++;
            end else begin
                e = expected_axes.pop_front();
                if (e.out_left_x !== m_data.out_left_x)
                    $display("%0t out_left_x exp %h got %h", $time, e.out_left_x,
                             m_data.out_left_x);
                if (e.out_left_y !== m_data.out_left_y)
                    $display("%0t out_left_y exp %h got %h", $time, e.out_left_y,
                             m_data.out_left_y);
                if (e.out_right_x !== m_data.out_right_x)
                    $display("%0t out_right_x exp %h got %h", $time, e.out_right_x,
                             m_data.out_right_x);
                if (e.out_right_y !== m_data.out_right_y)
                    $display("%0t out_right_y exp %h got %h", $time, e.out_right_y,
                             m_data.out_right_y);
                if (e !== m_data) begin
                    error_count++;
                end
            end
        end
    end

    // write one register and mirror it in the predictor
    task automatic write_reg(logic [2:0] idx, logic [MAG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_INVERT_MASK:    inv_mask_q   = val[3:0];
            REG_DEADZONE_LEFT:  dz_left_q    = val;
            REG_DEADZONE_RIGHT: dz_right_q   = val;
            REG_LINKED_LEFT:    link_left_q  = val[0];
            REG_LINKED_RIGHT:   link_right_q = val[0];
            REG_RESCALE_LEFT:   resc_left_q  = val[0];
            REG_RESCALE_RIGHT:  resc_right_q = val[0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] rand_axis(logic [MAG_W-1:0] dz);
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0: v = 16'($urandom);
            1: v = {1'b0, dz};
            2: v = ~{1'b0, dz};
            3: v = {1'b0, dz} + 16'($urandom_range(0, 3)) - 16'd2;
            4: v = $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 3))
                                        : 16'h8000 + 16'($urandom_range(0, 3));
            default: v = $urandom_range(0, 1) ? 16'($urandom_range(0, 200))
                                              : 16'hffff - 16'($urandom_range(0, 200));
        endcase
        return v;
    endfunction

    function automatic sdc_in_t rand_request();
        sdc_in_t a;
        a.left_x  = rand_axis(dz_left_q);
        a.left_y  = rand_axis(dz_left_q);
        a.right_x = rand_axis(dz_right_q);
        a.right_y = rand_axis(dz_right_q);
        return a;
    endfunction

    task automatic wait_drained();
        while (pending_axes.size() > 0 || s_valid || expected_axes.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // stimulus
    initial begin
        logic [15:0] edges [6];
        sdc_in_t     a;
        error_count = 0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_INVERT_MASK;
        cfg_wdata   = '0;
        inv_mask_q  = '0;
        dz_left_q   = '0;
        dz_right_q  = '0;
        link_left_q = 1'b0;
        link_right_q = 1'b0;
        resc_left_q = 1'b0;
        resc_right_q = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset config, then left deadzone 1000, right 32767, both rescaled
        edges = '{16'h0000, 16'hffff, 16'h7fff, 16'h8000, 16'd1000, ~16'd1000};
        for (int i = 0; i < 6; i++) begin
            a = '{edges[i], edges[5 - i], edges[(i + 2) % 6], edges[(i + 4) % 6]};
            pending_axes.push_back(a);
        end
        wait_drained();
        write_reg(REG_INVERT_MASK, 15'd5);
        write_reg(REG_DEADZONE_LEFT, 15'd1000);
        write_reg(REG_DEADZONE_RIGHT, 15'd32767);
        write_reg(REG_LINKED_RIGHT, 15'd1);
        write_reg(REG_RESCALE_LEFT, 15'd1);
        write_reg(REG_RESCALE_RIGHT, 15'd1);
        write_reg(REG_NONE, 15'h7fff);
        for (int i = 0; i < 6; i++) begin
            a = '{edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6], edges[5 - i]};
            pending_axes.push_back(a);
        end
        pending_axes.push_back('{16'd1000, 16'd999, 16'h7fff, 16'h7ffe});
        pending_axes.push_back('{16'd999, 16'd999, 16'h7ffe, 16'h8001});
        wait_drained();
        write_reg(REG_LINKED_LEFT, 15'd1);
        write_reg(REG_RESCALE_LEFT, 15'd0);
        pending_axes.push_back('{16'd1000, ~16'd100, 16'd5, 16'd5});
        pending_axes.push_back('{16'd10, ~16'd10, 16'h8000, 16'd5});

        // random phases over varied settings
        for (int p = 0; p < 12; p++) begin
            wait_drained();
            write_reg(REG_INVERT_MASK, 15'($urandom_range(0, 15)));
            case (p % 4)
                0: write_reg(REG_DEADZONE_LEFT, 15'd0);
                1: write_reg(REG_DEADZONE_LEFT, 15'($urandom_range(32760, 32767)));
                default: write_reg(REG_DEADZONE_LEFT, 15'($urandom_range(1, 32767)));
            endcase
            case (p % 3)
                0: write_reg(REG_DEADZONE_RIGHT, 15'd1);
                default: write_reg(REG_DEADZONE_RIGHT, 15'($urandom));
            endcase
            write_reg(REG_LINKED_LEFT, {14'd0, p[0]});
            write_reg(REG_LINKED_RIGHT, {14'd0, p[1]});
            write_reg(REG_RESCALE_LEFT, {14'd0, p[2] ^ p[0]});
            write_reg(REG_RESCALE_RIGHT, {14'd0, ~p[2]});
            for (int i = 0; i < 50; i++)
                pending_axes.push_back(rand_request());
        end
        wait_drained();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // timeout
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
